### design/brb_pkg.sv
// Package for the byte ring buffer with burst requests.
// Holds op and status codes, controller states and the control/status structs.
// No dependencies.
package brb_pkg;

	// Request opcodes
	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_RETRIEVE = 2'd1,
		OP_PEEK     = 2'd2,
		OP_FLUSH    = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_SHORT   = 2'd2
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE,
		S_BURST
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;   // request taken this cycle
		logic beat;     // one read burst byte this cycle
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic burst_go;   // current request is a valid retrieve/peek burst
		logic last_beat;  // burst byte in flight is the final one
	} sts_t;

endpackage

### design/brb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/brb_ctrl.sv
// Controller for the byte ring buffer: idle/burst state machine.
// Depends on brb_pkg.
module brb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  brb_pkg::sts_t sts,
	output brb_pkg::cmd_t cmd,
	output logic          busy
);
	import brb_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.beat   = 1'b0;
		busy       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = start;
				if (start && sts.burst_go) begin
					state_d = S_BURST;
				end
			end
			S_BURST: begin
				busy     = 1'b1;
				cmd.beat = 1'b1;
				if (sts.last_beat) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

endmodule

### design/brb_datapath.sv
// Datapath for the byte ring buffer: pointers, occupancy, insert request
// tracking, burst read address/count, storage RAM and result registers.
// Depends on brb_pkg and brb_ram.
module brb_datapath #(
	parameter int DEPTH     = 256,
	parameter int MAX_BURST = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  brb_pkg::cmd_t cmd,
	output brb_pkg::sts_t sts,
	input  logic [1:0]    op,
	input  logic [7:0]    byte_in,
	input  logic [6:0]    length,
	input  logic          last_in,
	input  logic          cfg_we,
	input  logic [8:0]    cfg_wdata,
	output logic          done,
	output logic [1:0]    status,
	output logic [7:0]    byte_out,
	output logic          byte_valid,
	output logic          last_out,
	output logic [8:0]    used_count
);
	import brb_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int QW = $clog2(DEPTH + 1);
	localparam int CW = (QW > 9) ? QW : 9;
	localparam int BW = $clog2(MAX_BURST + 1);

	// Queue state
	logic [PW-1:0] wptr_q, rptr_q;
	logic [QW-1:0] occ_q, qsize_q;
	logic          in_req_q, req_acc_q;
	logic [BW-1:0] bw_q;
	status_t       refuse_q;

	// Burst state
	logic [PW-1:0] bptr_q;
	logic [6:0]    bcnt_q;
	logic [QW-1:0] bafter_q;

	// Result registers
	logic          done_q, valid_q, last_q;
	status_t       status_q;
	logic [7:0]    byte_q;
	logic [8:0]    used_q;

	// Combinational helpers
	op_t           op_c;
	logic [CW-1:0] len_c, cfg_c;
	logic [QW-1:0] free_c, after_c;
	logic          len_bad, no_space, no_data;
	logic          ins_acc, ins_store;
	status_t       ins_code, ins_st;
	logic [BW-1:0] ins_bw;
	logic [CW:0]   rsum_c, rend_c;
	logic          ram_we;
	logic [PW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// Pointer step with wrap at the configured size
	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [QW-1:0] qs);
		logic [QW-1:0] n;
		n = QW'(p) + QW'(1);
		adv = (n >= qs) ? '0 : n[PW-1:0];
	endfunction

	// Occupancy to the 9-bit result field
	function automatic logic [8:0] to_used(input logic [QW-1:0] v);
		logic [CW-1:0] e;
		e = CW'(v);
		to_used = e[8:0];
	endfunction

	// Request checks
	always_comb begin
		op_c     = op_t'(op);
		len_c    = CW'(length);
		cfg_c    = CW'(cfg_wdata);
		free_c   = qsize_q - occ_q;
		len_bad  = (length == 7'd0) || (len_c > CW'(MAX_BURST));
		no_space = len_c > CW'(free_c);
		no_data  = len_c > CW'(occ_q);
		after_c  = (op_c == OP_RETRIEVE) ? (occ_q - QW'(length)) : occ_q;
		rsum_c   = (CW+1)'(rptr_q) + (CW+1)'(length);
		rend_c   = (rsum_c >= (CW+1)'(qsize_q)) ? (rsum_c - (CW+1)'(qsize_q)) : rsum_c;
	end

	// Insert admission: decided on the first byte, held for the rest
	always_comb begin
		if (!in_req_q) begin
			if (len_bad) begin
				ins_acc  = 1'b0;
				ins_code = ST_BAD_LEN;
				ins_bw   = '0;
			end else if (no_space) begin
				ins_acc  = 1'b0;
				ins_code = ST_SHORT;
				ins_bw   = '0;
			end else begin
				ins_acc  = 1'b1;
				ins_code = ST_OK;
				// remaining allowance kept as an offset from the burst limit
				ins_bw   = BW'(MAX_BURST) - BW'(length);
			end
		end else begin
			ins_acc  = req_acc_q;
			ins_code = refuse_q;
			ins_bw   = bw_q;
		end
		ins_store = ins_acc && (ins_bw < BW'(MAX_BURST));
		if (!ins_acc) begin
			ins_st = ins_code;
		end else if (ins_store) begin
			ins_st = ST_OK;
		end else begin
			ins_st = ST_BAD_LEN;
		end
	end

	// Status to controller
	assign sts.burst_go  = ((op_c == OP_RETRIEVE) || (op_c == OP_PEEK)) && !len_bad && !no_data;
	assign sts.last_beat = (bcnt_q == 7'd1);

	// Storage
	assign ram_we    = cmd.accept && (op_c == OP_INSERT) && ins_store;
	assign ram_raddr = cmd.beat ? bptr_q : rptr_q;

	brb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wptr_q),
		.wdata(byte_in),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Queue, burst and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			rptr_q    <= '0;
			occ_q     <= '0;
			qsize_q   <= QW'(DEPTH);
			in_req_q  <= 1'b0;
			req_acc_q <= 1'b0;
			bw_q      <= '0;
			refuse_q  <= ST_OK;
			bptr_q    <= '0;
			bcnt_q    <= '0;
			bafter_q  <= '0;
			done_q    <= 1'b0;
			valid_q   <= 1'b0;
			last_q    <= 1'b0;
			status_q  <= ST_OK;
			byte_q    <= '0;
			used_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				// clamp size to 1..DEPTH and empty the queue
				if (cfg_c == '0) begin
					qsize_q <= QW'(1);
				end else if (cfg_c > CW'(DEPTH)) begin
					qsize_q <= QW'(DEPTH);
				end else begin
					qsize_q <= cfg_c[QW-1:0];
				end
				wptr_q    <= '0;
				rptr_q    <= '0;
				occ_q     <= '0;
				in_req_q  <= 1'b0;
				req_acc_q <= 1'b0;
				bw_q      <= '0;
				refuse_q  <= ST_OK;
			end else if (cmd.accept) begin
				case (op_c) inside
					OP_INSERT: begin
						in_req_q  <= !last_in;
						req_acc_q <= ins_acc;
						refuse_q  <= ins_code;
						if (ins_store) begin
							wptr_q <= adv(wptr_q, qsize_q);
							occ_q  <= occ_q + QW'(1);
							bw_q   <= ins_bw + BW'(1);
							used_q <= to_used(occ_q + QW'(1));
						end else begin
							bw_q   <= ins_bw;
							used_q <= to_used(occ_q);
						end
						done_q   <= 1'b1;
						status_q <= ins_st;
						byte_q   <= '0;
						valid_q  <= 1'b0;
						last_q   <= last_in;
					end
					OP_FLUSH: begin
						wptr_q    <= '0;
						rptr_q    <= '0;
						occ_q     <= '0;
						in_req_q  <= 1'b0;
						req_acc_q <= 1'b0;
						bw_q      <= '0;
						refuse_q  <= ST_OK;
						done_q    <= 1'b1;
						status_q  <= ST_OK;
						byte_q    <= '0;
						valid_q   <= 1'b0;
						last_q    <= 1'b1;
						used_q    <= '0;
					end
					OP_RETRIEVE, OP_PEEK: begin
						in_req_q  <= 1'b0;
						req_acc_q <= 1'b0;
						if (len_bad || no_data) begin
							done_q   <= 1'b1;
							status_q <= len_bad ? ST_BAD_LEN : ST_SHORT;
							byte_q   <= '0;
							valid_q  <= 1'b0;
							last_q   <= 1'b1;
							used_q   <= to_used(occ_q);
						end else begin
							// first byte address is on the RAM now; queue up the next
							bptr_q   <= adv(rptr_q, qsize_q);
							bcnt_q   <= length;
							bafter_q <= after_c;
							if (op_c == OP_RETRIEVE) begin
								rptr_q <= rend_c[PW-1:0];
								occ_q  <= after_c;
							end
						end
					end
				endcase
			end else if (cmd.beat) begin
				// emit one burst byte
				done_q   <= 1'b1;
				status_q <= ST_OK;
				byte_q   <= ram_rdata;
				valid_q  <= 1'b1;
				last_q   <= (bcnt_q == 7'd1);
				used_q   <= to_used(bafter_q);
				bptr_q   <= adv(bptr_q, qsize_q);
				bcnt_q   <= bcnt_q - 7'd1;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign byte_out   = byte_q;
	assign byte_valid = valid_q;
	assign last_out   = last_q;
	assign used_count = used_q;

endmodule

### design/byte_ring_buffer_burst.sv
// Top level of the byte ring buffer with all-or-nothing burst requests.
// Depends on brb_pkg, brb_ctrl, brb_datapath (and brb_ram below it).
//
// A request is taken when start is high and busy is low; each result appears
// on the result ports for exactly one cycle with done high, and the receiver
// cannot hold results off. Insert, flush and refused requests give a single
// result, which shows the cycle after the request is taken, and a new
// request can be taken every cycle. A retrieve or peek of N bytes keeps busy
// high while its N bytes are read out, one byte a cycle through the storage
// RAM's single registered read port; each byte passes that port and then the
// result registers, and no request is taken while busy. cfg_we empties the queue.
module byte_ring_buffer_burst #(
	parameter int DEPTH     = 256,
	parameter int MAX_BURST = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] op,
	input  logic [7:0] byte_in,
	input  logic [6:0] length,
	input  logic       last_in,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] byte_out,
	output logic       byte_valid,
	output logic       last_out,
	output logic [8:0] used_count
);
	import brb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller
	brb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	// Datapath
	brb_datapath #(
		.DEPTH    (DEPTH),
		.MAX_BURST(MAX_BURST)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (op),
		.byte_in   (byte_in),
		.length    (length),
		.last_in   (last_in),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.status    (status),
		.byte_out  (byte_out),
		.byte_valid(byte_valid),
		.last_out  (last_out),
		.used_count(used_count)
	);

endmodule
